FILE: hw/rtl/tbd_pkg.sv
package tbd_pkg;

  // TEA round constant
  localparam logic [31:0] TEA_DELTA = 32'h9E3779B9;

  // Key register reset values
  localparam logic [31:0] KEY0_RESET = 32'd371;
  localparam logic [31:0] KEY1_RESET = 32'd215;
  localparam logic [31:0] KEY2_RESET = 32'd11;
  localparam logic [31:0] KEY3_RESET = 32'd12;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] KEY_IDX0 = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] KEY_IDX1 = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] KEY_IDX2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] KEY_IDX3 = 2'd3;

  typedef struct packed {
    logic [31:0] cipher_first;
    logic [31:0] cipher_second;
  } cipher_word_t;

  typedef struct packed {
    logic [31:0] plain_first;
    logic [31:0] plain_second;
  } plain_word_t;

  // Block halves as they travel down the chain
  typedef struct packed {
    logic [31:0] first;
    logic [31:0] second;
  } half_pair_t;

  typedef struct packed {
    logic [31:0] ka;
    logic [31:0] kb;
  } key_pair_t;

  // TEA mixing function on one half
  function automatic logic [31:0] mix_half(input logic [31:0] v,
                                           input logic [31:0] sum,
                                           input logic [31:0] ka,
                                           input logic [31:0] kb);
    mix_half = ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
  endfunction

endpackage

FILE: hw/rtl/tbd_cell.sv
// One half-round of TEA decryption. Even cells update the second half from
// the first, odd cells update the first half from the fresh second half.
module tbd_cell
  import tbd_pkg::*;
#(
  parameter logic [31:0] SUM         = 32'h0,
  parameter bit          SECOND_STEP = 1'b0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       valid_in,
  input  half_pair_t data_in,
  input  key_pair_t  key,
  output logic       valid,
  output half_pair_t data
);

  half_pair_t data_next;

  // Half-round update
  always_comb begin
    data_next = data_in;
    if (SECOND_STEP) begin
      data_next.first = data_in.first - mix_half(data_in.second, SUM, key.ka, key.kb);
    end else begin
      data_next.second = data_in.second - mix_half(data_in.first, SUM, key.ka, key.kb);
    end
  end

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule

FILE: hw/rtl/tea_block_decrypt_unit.sv
// An accepted cipher word reaches plain_valid through the chain of registered
// half-round cells.
// Throughput: one block per cycle; the whole cell chain holds while a
// finished plain word waits under plain_stall.
// Reset: clears every valid flag in the chain and loads the key reset values.
module tea_block_decrypt_unit
  import tbd_pkg::*;
#(
  parameter int ROUND_COUNT = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic                   cipher_valid,
  output logic                   cipher_stall,
  input  cipher_word_t           cipher,
  output logic                   plain_valid,
  input  logic                   plain_stall,
  output plain_word_t            plain
);

  localparam int STAGES = 2 * ROUND_COUNT;

  logic [31:0] key0;
  logic [31:0] key1;
  logic [31:0] key2;
  logic [31:0] key3;
  logic        advance;
  logic        vld [0:STAGES];
  half_pair_t  st  [0:STAGES];
  key_pair_t   key_a;
  key_pair_t   key_b;

  // Key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key0 <= KEY0_RESET;
      key1 <= KEY1_RESET;
      key2 <= KEY2_RESET;
      key3 <= KEY3_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        KEY_IDX0: key0 <= cfg_data;
        KEY_IDX1: key1 <= cfg_data;
        KEY_IDX2: key2 <= cfg_data;
        KEY_IDX3: key3 <= cfg_data;
        default:  ;
      endcase
    end
  end

  assign key_a = '{ka: key2, kb: key3};
  assign key_b = '{ka: key0, kb: key1};

  // Chain moves unless the last word is held
  assign advance      = !(vld[STAGES] && plain_stall);
  assign cipher_stall = !advance;

  assign vld[0] = cipher_valid;
  assign st[0]  = '{first: cipher.cipher_first, second: cipher.cipher_second};

  // Cell chain, two cells per round
  for (genvar j = 0; j < STAGES; j++) begin : g_cell
    localparam int          RND    = j / 2;
    localparam logic [63:0] SUM_W  = 64'(TEA_DELTA) * 64'(ROUND_COUNT - RND);
    localparam logic [31:0] SUM_J  = SUM_W[31:0];
    localparam bit          SECOND = (j % 2) == 1;

    tbd_cell #(
      .SUM         (SUM_J),
      .SECOND_STEP (SECOND)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (advance),
      .valid_in (vld[j]),
      .data_in  (st[j]),
      .key      (SECOND ? key_b : key_a),
      .valid    (vld[j+1]),
      .data     (st[j+1])
    );
  end

  assign plain_valid = vld[STAGES];
  assign plain       = '{plain_first: st[STAGES].first, plain_second: st[STAGES].second};

endmodule

FILE: hw/rtl/tbd_checker.sv
module tbd_checker
  import tbd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        cipher_stall,
  input logic        plain_valid,
  input logic        plain_stall,
  input plain_word_t plain
);

  // Input is held back only while a finished word is held at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cipher_stall |-> (plain_valid && plain_stall))
    else $error("cipher_stall without a held plain word");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !plain_valid)
    else $error("plain_valid right after reset");

  // A held word stays valid
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (plain_valid && plain_stall) |=> plain_valid)
    else $error("plain word dropped under stall");

  // A held word keeps its value
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (plain_valid && plain_stall) |=> $stable(plain))
    else $error("plain word changed under stall");

endmodule

bind tea_block_decrypt_unit tbd_checker u_tbd_checker (
  .clk          (clk),
  .rst          (rst),
  .cipher_stall (cipher_stall),
  .plain_valid  (plain_valid),
  .plain_stall  (plain_stall),
  .plain        (plain)
);

FILE: tb/sv/tea_block_decrypt_unit_tb.sv
`timescale 1ns / 100ps

module tea_block_decrypt_unit_tb;
  import tbd_pkg::*;

  localparam int ROUNDS = 32;
  // half-round cells between an accepted cipher word and its plain word
  localparam int PIPE_DEPTH = 2 * ROUNDS;
  localparam int RANDOM_PER_PHASE = 146;
  localparam int MAX_PRINTED = 40;
  // worst case is far below this: ~825 words, each with the longest random gap
  // and the longest random stall, plus the drain pauses between key settings
  localparam longint LIMIT_NS = 64'd5_000_000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = KEY_IDX0;
  logic [31:0]            cfg_data = '0;
  logic                   cipher_valid = 1'b0;
  logic                   cipher_stall;
  cipher_word_t           cipher = '0;
  logic                   plain_valid;
  logic                   plain_stall = 1'b0;
  plain_word_t            plain;

  // key copy used for prediction, indexed by register index
  logic [31:0]  key_model [4];
  cipher_word_t cipher_queue [$];
  plain_word_t  expected_plain [$];
  bit           quiet = 1'b0;
  int           send_gap = 0;
  int           hold_gap = 0;
  int           error_count = 0;
  int           checked_count = 0;
  int           key_settings = 1;

  tea_block_decrypt_unit #(
    .ROUND_COUNT(ROUNDS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cipher_valid(cipher_valid),
    .cipher_stall(cipher_stall),
    .cipher      (cipher),
    .plain_valid (plain_valid),
    .plain_stall (plain_stall),
    .plain       (plain)
  );

  always #5 clk = ~clk;

  // one TEA half-round mixing term
  function automatic logic [31:0] tea_feistel(input logic [31:0] v, input logic [31:0] s,
                                              input logic [31:0] ka, input logic [31:0] kb);
    logic [31:0] shl;
    logic [31:0] shr;
    shl = v << 4;
    shr = v >> 5;
    return (shl + ka) ^ (v + s) ^ (shr + kb);
  endfunction

  // full decryption over ROUNDS rounds with the current key copy
  function automatic plain_word_t decrypt_block(input cipher_word_t c);
    logic [31:0] left;
    logic [31:0] right;
    logic [31:0] round_sum;
    plain_word_t p;
    left = c.cipher_first;
    right = c.cipher_second;
    round_sum = TEA_DELTA * ROUNDS;
    for (int r = 0; r < ROUNDS; r++) begin
      right -= tea_feistel(left, round_sum, key_model[KEY_IDX2], key_model[KEY_IDX3]);
      left -= tea_feistel(right, round_sum, key_model[KEY_IDX0], key_model[KEY_IDX1]);
      round_sum -= TEA_DELTA;
    end
    p.plain_first = left;
    p.plain_second = right;
    return p;
  endfunction

  // mostly uniform, sometimes near the ends of the range
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    case ($urandom_range(0, 7))
      0: w = $urandom_range(0, 15);
      1: w = 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_plain(input plain_word_t got);
    plain_word_t want;
    if (expected_plain.size() == 0) begin
      report_mismatch($sformatf("plain word %h with none expected", got));
    end else begin
      want = expected_plain.pop_front();
      checked_count++;
      if (got.plain_first !== want.plain_first)
        report_mismatch($sformatf("plain_first %h, expected %h", got.plain_first,
                                  want.plain_first));
      if (got.plain_second !== want.plain_second)
        report_mismatch($sformatf("plain_second %h, expected %h", got.plain_second,
                                  want.plain_second));
    end
  endtask

  // register write; only called with nothing in flight
  task automatic write_key(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    key_model[idx] = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_keys(input logic [31:0] k0, input logic [31:0] k1,
                           input logic [31:0] k2, input logic [31:0] k3);
    write_key(KEY_IDX0, k0);
    write_key(KEY_IDX1, k1);
    write_key(KEY_IDX2, k2);
    write_key(KEY_IDX3, k3);
    key_settings++;
  endtask

  task automatic push_cipher(input logic [31:0] first, input logic [31:0] second);
    cipher_word_t c;
    c.cipher_first = first;
    c.cipher_second = second;
    cipher_queue.push_back(c);
  endtask

  task automatic push_random(input int count);
    repeat (count) push_cipher(random_word(), random_word());
  endtask

  // waits until every expected word is back, then lets the chain settle
  task automatic wait_drained();
    do @(posedge clk);
    while (cipher_queue.size() != 0 || cipher_valid || expected_plain.size() != 0);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  // driver: cipher words from the queue, with random idle bursts
  always @(posedge clk) begin
    logic         next_valid;
    cipher_word_t next_word;
    if (rst) begin
      cipher_valid <= 1'b0;
    end else begin
      next_valid = cipher_valid;
      next_word = cipher;
      if (cipher_valid && !cipher_stall) begin
        expected_plain.push_back(decrypt_block(cipher));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(1, 13) - 1;
        end else if (cipher_queue.size() != 0) begin
          next_valid = 1'b1;
          next_word = cipher_queue.pop_front();
        end
      end
      cipher_valid <= next_valid;
      cipher <= next_word;
    end
  end

  // monitor: check accepted plain words, stall in random bursts
  always @(posedge clk) begin
    logic stall_next;
    if (rst) begin
      plain_stall <= 1'b0;
    end else begin
      if (plain_valid && !plain_stall)
        check_plain(plain);
      if (hold_gap > 0) begin
        hold_gap--;
        stall_next = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        hold_gap = $urandom_range(1, 13) - 1;
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      plain_stall <= stall_next;
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("[tea_block_decrypt_unit] ERROR");
    $finish;
  end

  initial begin
    key_model[KEY_IDX0] = KEY0_RESET;
    key_model[KEY_IDX1] = KEY1_RESET;
    key_model[KEY_IDX2] = KEY2_RESET;
    key_model[KEY_IDX3] = KEY3_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset keys: field extremes and bit patterns
    push_cipher(32'h0000_0000, 32'h0000_0000);
    push_cipher(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cipher(32'h0000_0000, 32'hFFFF_FFFF);
    push_cipher(32'hFFFF_FFFF, 32'h0000_0000);
    push_cipher(32'hAAAA_AAAA, 32'h5555_5555);
    push_cipher(32'h5555_5555, 32'hAAAA_AAAA);
    push_cipher(32'h8000_0000, 32'h0000_0001);
    push_cipher(32'h0000_0001, 32'h8000_0000);
    push_cipher(32'h7FFF_FFFF, 32'h8000_0000);
    push_cipher(32'h0000_001F, 32'hF800_0000);
    push_cipher(TEA_DELTA, 32'hC6EF_3720);
    push_cipher(32'h0123_4567, 32'h89AB_CDEF);
    wait_drained();

    // some of the same words plus random words with all-zero, then all-one keys
    load_keys('0, '0, '0, '0);
    push_cipher(32'h0000_0000, 32'h0000_0000);
    push_cipher(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cipher(32'h8000_0000, 32'h0000_0001);
    push_cipher(32'h0123_4567, 32'h89AB_CDEF);
    push_random(RANDOM_PER_PHASE);
    wait_drained();

    load_keys('1, '1, '1, '1);
    push_cipher(32'h0000_0000, 32'h0000_0000);
    push_cipher(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cipher(32'h8000_0000, 32'h0000_0001);
    push_cipher(32'h0123_4567, 32'h89AB_CDEF);
    push_random(RANDOM_PER_PHASE);
    wait_drained();

    // mixed extreme keys, then random keys
    load_keys('0, '1, '1, '0);
    push_random(RANDOM_PER_PHASE / 2);
    wait_drained();

    repeat (2) begin
      load_keys($urandom, $urandom, $urandom, $urandom);
      push_random(RANDOM_PER_PHASE);
      wait_drained();
    end

    // last stretch back to back, no gaps and no stalls
    quiet = 1'b1;
    load_keys($urandom, $urandom, $urandom, $urandom);
    push_random(RANDOM_PER_PHASE);
    wait_drained();

    $display("checked %0d decrypted words over %0d key settings,", checked_count,
             key_settings);
    $display("with random gaps and stalls, then a back-to-back stretch");
    if (error_count == 0) begin
      $display("[tea_block_decrypt_unit] OK");
    end else begin
      $display("[tea_block_decrypt_unit] ERROR");
    end
    $finish;
  end

endmodule
